### hw/rtl/miu_pkg.sv
// Shared types and constants of the MIPS-I integer execute unit.
// Opcode, funct and status codes, and the multiply/divide request and response records.
// No dependencies.
package miu_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  localparam logic [4:0] RT_BLTZ    = 5'd0;
  localparam logic [4:0] RT_BGEZ    = 5'd1;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_UNSUP  = 2'd1;
  localparam logic [1:0] STS_ADDR   = 2'd2;
  localparam logic [1:0] STS_EXIT   = 2'd3;

  localparam logic [31:0] EXIT_CODE = 32'd10;
  localparam logic [4:0]  V0_INDEX  = 5'd2;
  localparam logic [4:0]  RA_INDEX  = 5'd31;

  typedef enum logic [1:0] {
    MD_MULT  = 2'd0,
    MD_MULTU = 2'd1,
    MD_DIV   = 2'd2,
    MD_DIVU  = 2'd3
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

endpackage

### hw/rtl/miu_muldiv.sv
// Iterative multiply/divide unit: one bit per cycle, 32 steps, then a sign fix-up of the result.
// Depends on miu_pkg.
module miu_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  miu_pkg::md_req_t req,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output miu_pkg::md_rsp_t rsp
);
  import miu_pkg::*;

  logic        busy_r, fin_r, is_div_r, neg_lo_r, neg_hi_r;
  logic [4:0]  cnt_r;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] mb_r;
  logic        done_r;
  logic [31:0] hi_res_r, lo_res_r;

  logic        sgn, a_neg, b_neg;
  logic [31:0] ma, mb;
  logic [32:0] mul_sum;
  logic [33:0] trial;
  logic [63:0] prod_neg;

  assign sgn   = (req.op == MD_MULT) || (req.op == MD_DIV);
  assign a_neg = sgn & a[31];
  assign b_neg = sgn & b[31];
  assign ma    = a_neg ? (32'd0 - a) : a;
  assign mb    = b_neg ? (32'd0 - b) : b;

  assign mul_sum  = {1'b0, prod_r[63:32]} + (prod_r[0] ? {1'b0, mb_r} : 33'd0);
  assign trial    = {1'b0, prod_r[63:31]} - {2'b00, mb_r};
  assign prod_neg = 64'd0 - prod_r;

  always_comb begin
    if (is_div_r) begin
      prod_nxt = trial[33] ? {prod_r[62:0], 1'b0} : {trial[31:0], prod_r[30:0], 1'b1};
    end else begin
      prod_nxt = {mul_sum, prod_r[31:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r && !busy_r && !req.start;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r   <= {32'd0, ma};
      mb_r     <= mb;
      is_div_r <= (req.op == MD_DIV) || (req.op == MD_DIVU);
      neg_lo_r <= a_neg ^ b_neg;
      neg_hi_r <= a_neg;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
    if (fin_r) begin
      if (is_div_r) begin
        lo_res_r <= neg_lo_r ? prod_neg[31:0] : prod_r[31:0];
        hi_res_r <= neg_hi_r ? (32'd0 - prod_r[63:32]) : prod_r[63:32];
      end else begin
        lo_res_r <= neg_lo_r ? prod_neg[31:0] : prod_r[31:0];
        hi_res_r <= neg_lo_r ? prod_neg[63:32] : prod_r[63:32];
      end
    end
  end

  assign rsp = '{done: done_r, hi: hi_res_r, lo: lo_res_r};

  property p_done_after_fin;
    @(posedge clk) disable iff (!rst_n) fin_r && !busy_r && !req.start |=> rsp.done;
  endproperty
  a_done_after_fin: assert property (p_done_after_fin) else $error("md: missing done");

  property p_no_overlap;
    @(posedge clk) disable iff (!rst_n) busy_r |-> !fin_r;
  endproperty
  a_no_overlap: assert property (p_no_overlap) else $error("md: busy and fin together");

  property p_done_single;
    @(posedge clk) disable iff (!rst_n) rsp.done |=> !rsp.done;
  endproperty
  a_done_single: assert property (p_done_single) else $error("md: done held");

endmodule

### hw/rtl/mips_integer_execute_unit.sv
// MIPS-I integer execute unit: register file and data memory in synchronous RAMs.
// One transaction at a time: the next is accepted only after the result is registered at
// the output, which waits while out_stall holds a pending result.
// Reset: registers (through their valid bits), hi, lo and pc clear at once; data memory
// is then swept to zero word by word, during which no input is accepted.
// Uses miu_pkg, miu_muldiv.
module mips_integer_execute_unit #(
  parameter int MEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic        out_wrote_register,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic [1:0]  out_status
);
  import miu_pkg::*;

  localparam int          AW       = $clog2(MEM_WORDS);
  localparam logic [31:0] ADDR_LIM = 32'(MEM_WORDS * 4);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_MEMRD = 6'b001000,
    S_MDWT  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [31:0] a_q_r, b_q_r;
  logic        a_v_r, b_v_r;
  logic [31:0] dm_mem [MEM_WORDS];
  logic [31:0] dm_q_r;
  logic [AW-1:0] clr_r;

  logic [31:0] ins_r, pc_r, hi_r, lo_r;
  logic [31:0] res_npc_r, res_val_r;
  logic        res_wr_r;
  logic [4:0]  res_idx_r;
  logic [1:0]  res_sts_r;

  logic        out_valid_r, out_wr_r;
  logic [31:0] out_npc_r, out_val_r;
  logic [4:0]  out_idx_r;
  logic [1:0]  out_sts_r;

  logic        acc, out_free;
  logic [4:0]  in_rs, in_rb;

  logic [5:0]  op, fn;
  logic [4:0]  rs_f, rt_f, rd_f, sh_f;
  logic [15:0] imm;
  logic [31:0] simm, a, b, npc4, btarget, jtarget, addr;
  logic        bad_b, bad_h, bad_w;

  logic [31:0] ex_npc, ex_val;
  logic        ex_wr;
  logic [4:0]  ex_idx;
  logic [1:0]  ex_sts;
  logic        hi_we, lo_we;
  logic [31:0] hi_wd, lo_wd;
  logic        dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0] dm_wdata;
  logic [31:0] ld_byte, ld_half;
  logic [4:0]  lane_sh;
  md_req_t     md_req;
  md_rsp_t     md_rsp;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign in_rs = in_instruction[25:21];
  assign in_rb = (in_instruction[31:26] == OP_SPECIAL && in_instruction[5:0] == FN_SYSCALL) ?
                 V0_INDEX : in_instruction[20:16];

  assign op   = ins_r[31:26];
  assign rs_f = ins_r[25:21];
  assign rt_f = ins_r[20:16];
  assign rd_f = ins_r[15:11];
  assign sh_f = ins_r[10:6];
  assign fn   = ins_r[5:0];
  assign imm  = ins_r[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign a    = a_v_r ? a_q_r : 32'd0;
  assign b    = b_v_r ? b_q_r : 32'd0;
  assign npc4 = pc_r + 32'd4;
  assign btarget = npc4 + {simm[29:0], 2'b00};
  assign jtarget = {npc4[31:28], ins_r[25:0], 2'b00};
  assign addr    = a + simm;
  assign bad_b   = !(addr < ADDR_LIM);
  assign bad_h   = bad_b || addr[0];
  assign bad_w   = bad_b || (addr[1:0] != 2'b00);

  assign lane_sh = {addr[1:0], 3'b000};
  assign ld_byte = {24'd0, 8'(dm_q_r >> lane_sh)};
  assign ld_half = {16'd0, 16'(dm_q_r >> {addr[1], 4'b0000})};

  // register file: two read ports registered at accept, one write port at commit
  always_ff @(posedge clk) begin
    if (acc) begin
      a_q_r <= rf_mem[in_rs];
      b_q_r <= rf_mem[in_rb];
    end
    if (state_r == S_FIN && out_free && res_wr_r) begin
      rf_mem[res_idx_r] <= res_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (state_r == S_FIN && out_free && res_wr_r) begin
      rf_vld_r[res_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_v_r <= rf_vld_r[in_rs];
      b_v_r <= rf_vld_r[in_rb];
      ins_r <= in_instruction;
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    dm_q_r <= dm_mem[addr[AW+1:2]];
  end

  miu_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .a     (a),
    .b     (b),
    .rsp   (md_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    ex_npc    = npc4;
    ex_wr     = 1'b0;
    ex_idx    = 5'd0;
    ex_val    = 32'd0;
    ex_sts    = STS_OK;
    hi_we     = 1'b0;
    lo_we     = 1'b0;
    hi_wd     = a;
    lo_wd     = a;
    dm_we     = 1'b0;
    dm_waddr  = addr[AW+1:2];
    dm_wdata  = b;
    md_req.start = 1'b0;
    md_req.op    = md_op_t'(fn[1:0]);

    unique case (state_r)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_r;
        dm_wdata = 32'd0;
        if (clr_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        if (op == OP_SPECIAL) begin
          unique case (fn) inside
            FN_SLL:  begin ex_idx = rd_f; ex_val = b << sh_f; end
            FN_SRL:  begin ex_idx = rd_f; ex_val = b >> sh_f; end
            FN_SRA:  begin ex_idx = rd_f; ex_val = 32'($signed(b) >>> sh_f); end
            FN_SLLV: begin ex_idx = rd_f; ex_val = b << a[4:0]; end
            FN_SRLV: begin ex_idx = rd_f; ex_val = b >> a[4:0]; end
            FN_SRAV: begin ex_idx = rd_f; ex_val = 32'($signed(b) >>> a[4:0]); end
            FN_JR:   ex_npc = a;
            FN_JALR: begin ex_idx = rd_f; ex_val = npc4; ex_npc = a; end
            FN_SYSCALL: if (b == EXIT_CODE) ex_sts = STS_EXIT;
            FN_MFHI: begin ex_idx = rd_f; ex_val = hi_r; end
            FN_MTHI: hi_we = 1'b1;
            FN_MFLO: begin ex_idx = rd_f; ex_val = lo_r; end
            FN_MTLO: lo_we = 1'b1;
            FN_MULT, FN_MULTU: begin
              md_req.start = 1'b1;
              state_nxt    = S_MDWT;
            end
            FN_DIV, FN_DIVU: begin
              if (b != 32'd0) begin
                md_req.start = 1'b1;
                state_nxt    = S_MDWT;
              end
            end
            FN_ADD, FN_ADDU: begin ex_idx = rd_f; ex_val = a + b; end
            FN_SUB, FN_SUBU: begin ex_idx = rd_f; ex_val = a - b; end
            FN_AND:  begin ex_idx = rd_f; ex_val = a & b; end
            FN_OR:   begin ex_idx = rd_f; ex_val = a | b; end
            FN_XOR:  begin ex_idx = rd_f; ex_val = a ^ b; end
            FN_NOR:  begin ex_idx = rd_f; ex_val = ~(a | b); end
            FN_SLT:  begin ex_idx = rd_f; ex_val = {31'd0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin ex_idx = rd_f; ex_val = {31'd0, a < b}; end
            default: ex_sts = STS_UNSUP;
          endcase
        end else begin
          unique case (op) inside
            OP_REGIMM: begin
              if (rt_f == RT_BLTZ) begin
                if (a[31]) ex_npc = btarget;
              end else if (rt_f == RT_BGEZ) begin
                if (!a[31]) ex_npc = btarget;
              end else begin
                ex_sts = STS_UNSUP;
              end
            end
            OP_J:    ex_npc = jtarget;
            OP_JAL:  begin ex_idx = RA_INDEX; ex_val = npc4; ex_npc = jtarget; end
            OP_BEQ:  if (a == b) ex_npc = btarget;
            OP_BNE:  if (a != b) ex_npc = btarget;
            OP_BLEZ: if (a == 32'd0 || a[31]) ex_npc = btarget;
            OP_BGTZ: if (a != 32'd0 && !a[31]) ex_npc = btarget;
            OP_ADDI, OP_ADDIU: begin ex_idx = rt_f; ex_val = a + simm; end
            OP_SLTI:  begin ex_idx = rt_f; ex_val = {31'd0, $signed(a) < $signed(simm)}; end
            OP_SLTIU: begin ex_idx = rt_f; ex_val = {31'd0, a < simm}; end
            OP_ANDI:  begin ex_idx = rt_f; ex_val = a & {16'd0, imm}; end
            OP_ORI:   begin ex_idx = rt_f; ex_val = a | {16'd0, imm}; end
            OP_XORI:  begin ex_idx = rt_f; ex_val = a ^ {16'd0, imm}; end
            OP_LUI:   begin ex_idx = rt_f; ex_val = {imm, 16'd0}; end
            OP_LB, OP_LBU, OP_SB: begin
              if (bad_b) ex_sts = STS_ADDR;
              else state_nxt = S_MEMRD;
            end
            OP_LH, OP_LHU, OP_SH: begin
              if (bad_h) ex_sts = STS_ADDR;
              else state_nxt = S_MEMRD;
            end
            OP_LW: begin
              if (bad_w) ex_sts = STS_ADDR;
              else state_nxt = S_MEMRD;
            end
            OP_SW: begin
              if (bad_w) ex_sts = STS_ADDR;
              else dm_we = 1'b1;
            end
            default: ex_sts = STS_UNSUP;
          endcase
        end
      end
      S_MEMRD: begin
        state_nxt = S_FIN;
        unique case (op) inside
          OP_LB:  begin ex_idx = rt_f; ex_val = {{24{ld_byte[7]}}, ld_byte[7:0]}; end
          OP_LBU: begin ex_idx = rt_f; ex_val = ld_byte; end
          OP_LH:  begin ex_idx = rt_f; ex_val = {{16{ld_half[15]}}, ld_half[15:0]}; end
          OP_LHU: begin ex_idx = rt_f; ex_val = ld_half; end
          OP_LW:  begin ex_idx = rt_f; ex_val = dm_q_r; end
          OP_SB: begin
            dm_we    = 1'b1;
            dm_wdata = (dm_q_r & ~(32'h0000_00FF << lane_sh)) | ({24'd0, b[7:0]} << lane_sh);
          end
          OP_SH: begin
            dm_we    = 1'b1;
            dm_wdata = (dm_q_r & ~(32'h0000_FFFF << {addr[1], 4'b0000}))
                     | ({16'd0, b[15:0]} << {addr[1], 4'b0000});
          end
          default: ex_idx = 5'd0;
        endcase
      end
      S_MDWT: begin
        if (md_rsp.done) begin
          hi_we     = 1'b1;
          lo_we     = 1'b1;
          hi_wd     = md_rsp.hi;
          lo_wd     = md_rsp.lo;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ex_wr = (ex_idx != 5'd0);
    if (!ex_wr) begin
      ex_val = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pc_r        <= 32'd0;
      hi_r        <= 32'd0;
      lo_r        <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (hi_we) hi_r <= hi_wd;
      if (lo_we) lo_r <= lo_wd;
      if (state_r == S_FIN && out_free) begin
        pc_r        <= res_npc_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      res_npc_r <= ex_npc;
      res_sts_r <= ex_sts;
      res_wr_r  <= ex_wr;
      res_idx_r <= ex_idx;
      res_val_r <= ex_val;
    end else if (state_r == S_MEMRD) begin
      res_wr_r  <= ex_wr;
      res_idx_r <= ex_idx;
      res_val_r <= ex_val;
    end
    if (state_r == S_FIN && out_free) begin
      out_npc_r <= res_npc_r;
      out_wr_r  <= res_wr_r;
      out_idx_r <= res_idx_r;
      out_val_r <= res_val_r;
      out_sts_r <= res_sts_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_pc        = out_npc_r;
  assign out_wrote_register = out_wr_r;
  assign out_dest_index     = out_idx_r;
  assign out_dest_value     = out_val_r;
  assign out_status         = out_sts_r;

  property p_no_r0_write;
    @(posedge clk) disable iff (!rst_n) out_valid |-> !(out_wrote_register && out_dest_index == 5'd0);
  endproperty
  a_no_r0_write: assert property (p_no_r0_write) else $error("result reports write to r0");

  property p_nowrite_zero;
    @(posedge clk) disable iff (!rst_n)
      out_valid && !out_wrote_register |-> out_dest_index == 5'd0 && out_dest_value == 32'd0;
  endproperty
  a_nowrite_zero: assert property (p_nowrite_zero) else $error("dest fields set without write");

  property p_md_start_exec;
    @(posedge clk) disable iff (!rst_n) md_req.start |-> state_r == S_EXEC;
  endproperty
  a_md_start_exec: assert property (p_md_start_exec) else $error("mul/div start outside exec");

  property p_accept_to_exec;
    @(posedge clk) disable iff (!rst_n) in_valid && !in_stall |=> state_r == S_EXEC;
  endproperty
  a_accept_to_exec: assert property (p_accept_to_exec) else $error("accepted transaction lost");

endmodule
